[src/sacl_pkg.sv]
`timescale 1ns / 1ps
package sacl_pkg;
  localparam int NUM_WAYS = 8;
  localparam int NUM_SETS = 1024;
  localparam int ADDR_W   = 32;
  localparam int SET_W    = 10;
  localparam int WAY_W    = 3;
  localparam int CNT_W    = 32;
  localparam int TAG_W    = 32;
  localparam int WAYS_W   = 4;
  localparam int OFF_W    = 5;
  localparam int SETB_W   = 4;
  localparam int MAX_OFF  = 16;
  localparam int MAX_SETB = 10;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [1:0] REG_WAYS = 2'd0;
  localparam logic [1:0] REG_OFF  = 2'd1;
  localparam logic [1:0] REG_SETB = 2'd2;

  typedef struct packed {
    logic             vld;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] stamp;
  } way_t;

  typedef way_t [NUM_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic [SET_W-1:0] set;
    logic [TAG_W-1:0] tag;
  } req_t;
endpackage

[src/sacl_ram.sv]
`timescale 1ns / 1ps
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[src/sacl_front.sv]
`timescale 1ns / 1ps
module sacl_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [sacl_pkg::ADDR_W-1:0]    address_i,
  input  logic [sacl_pkg::OFF_W-1:0]     offset_bits_i,
  input  logic [sacl_pkg::SETB_W-1:0]    set_bits_i,
  input  logic                           busy_i,
  input  logic                           req_pop_i,
  output logic                           req_valid_o,
  output sacl_pkg::req_t                 req_o
);
  import sacl_pkg::*;

  logic [OFF_W-1:0]  off;
  logic [SETB_W-1:0] sb;
  logic [5:0]        shamt;
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  set_mask;
  req_t              dec;
  req_t              q_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;
  logic              do_push, do_pop;

  always_comb begin
    off      = (offset_bits_i > OFF_W'(MAX_OFF)) ? OFF_W'(MAX_OFF) : offset_bits_i;
    sb       = (set_bits_i > SETB_W'(MAX_SETB)) ? SETB_W'(MAX_SETB) : set_bits_i;
    shamt    = {1'b0, off} + {2'b00, sb};
    shifted  = address_i >> off;
    set_mask = ~({SET_W{1'b1}} << sb);
    dec.set  = shifted[SET_W-1:0] & set_mask;
    dec.tag  = TAG_W'(address_i >> shamt);
  end

  assign full        = (cnt_q == 2'd2) || busy_i;
  assign do_push     = push && !full;
  assign req_valid_o = (cnt_q != 2'd0);
  assign do_pop      = req_pop_i && req_valid_o;
  assign req_o       = q_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule

[src/sacl_back.sv]
`timescale 1ns / 1ps
module sacl_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [sacl_pkg::WAYS_W-1:0]  ways_in_use_i,
  input  logic                         req_valid_i,
  input  sacl_pkg::req_t               req_i,
  output logic                         req_pop_o,
  output logic                         busy_o,
  input  logic                         pop,
  output logic                         empty,
  output logic                         hit_o,
  output logic [sacl_pkg::WAY_W-1:0]   way_used_o,
  output logic [sacl_pkg::SET_W-1:0]   set_index_o,
  output logic                         filled_empty_o,
  output logic [sacl_pkg::CNT_W-1:0]   hit_count_o,
  output logic [sacl_pkg::CNT_W-1:0]   access_count_o
);
  import sacl_pkg::*;

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_UPD} state_e;

  state_e           state_q;
  logic [SET_W-1:0] clr_cnt_q;
  req_t             cur_q;
  logic [CNT_W-1:0] acc_q, hits_q;
  logic             out_vld_q;

  logic             we;
  logic [SET_W-1:0] waddr, raddr;
  row_t             wdata, rdata, new_row;

  logic [WAYS_W-1:0]   wq;
  logic [NUM_WAYS-1:0] inuse, match, inval;
  logic                hit, filled, out_free, done;
  logic [WAY_W-1:0]    chosen, hit_way, inv_way;
  logic [CNT_W-1:0]    min_st [NUM_WAYS];
  logic [WAY_W-1:0]    min_ix [NUM_WAYS];
  logic                min_ok [NUM_WAYS];
  logic [CNT_W-1:0]    acc_n, hits_n;

  sacl_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    if (ways_in_use_i == '0) wq = WAYS_W'(1);
    else if (ways_in_use_i > WAYS_W'(NUM_WAYS)) wq = WAYS_W'(NUM_WAYS);
    else wq = ways_in_use_i;
    for (int w = 0; w < NUM_WAYS; w++) begin
      inuse[w] = (WAYS_W'(w) < wq);
      match[w] = inuse[w] && rdata[w].vld && (rdata[w].tag == cur_q.tag);
      inval[w] = inuse[w] && !rdata[w].vld;
      min_st[w] = rdata[w].stamp;
      min_ix[w] = WAY_W'(w);
      min_ok[w] = inuse[w];
    end
    hit_way = '0;
    inv_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (inval[w]) inv_way = WAY_W'(w);
    end
    // oldest stamp, tree; ties keep the lower way
    for (int s = 1; s < NUM_WAYS; s = s * 2) begin
      for (int i = 0; i + s < NUM_WAYS; i = i + 2 * s) begin
        if (min_ok[i+s] && (!min_ok[i] || (min_st[i+s] < min_st[i]))) begin
          min_st[i] = min_st[i+s];
          min_ix[i] = min_ix[i+s];
          min_ok[i] = 1'b1;
        end
      end
    end
    hit    = |match;
    filled = !hit && (|inval);
    chosen = hit ? hit_way : (filled ? inv_way : min_ix[0]);
    new_row = rdata;
    new_row[chosen].vld   = 1'b1;
    new_row[chosen].tag   = cur_q.tag;
    new_row[chosen].stamp = acc_q;
    acc_n  = (acc_q == '1) ? acc_q : acc_q + CNT_W'(1);
    hits_n = (hit && hits_q != '1) ? hits_q + CNT_W'(1) : hits_q;
  end

  assign out_free  = !out_vld_q || pop;
  assign done      = (state_q == S_UPD) && out_free;
  assign req_pop_o = (state_q == S_IDLE) && req_valid_i;
  assign busy_o    = (state_q == S_CLR);
  assign empty     = !out_vld_q;
  assign raddr     = (state_q == S_IDLE) ? req_i.set : cur_q.set;

  always_comb begin
    we    = 1'b0;
    waddr = cur_q.set;
    wdata = new_row;
    if (state_q == S_CLR) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (done) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      clr_cnt_q      <= '0;
      cur_q          <= '0;
      acc_q          <= '0;
      hits_q         <= '0;
      out_vld_q      <= 1'b0;
      hit_o          <= 1'b0;
      way_used_o     <= '0;
      set_index_o    <= '0;
      filled_empty_o <= 1'b0;
      hit_count_o    <= '0;
      access_count_o <= '0;
    end else begin
      if (done) out_vld_q <= 1'b1;
      else if (pop && out_vld_q) out_vld_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_cnt_q <= clr_cnt_q + SET_W'(1);
          if (clr_cnt_q == SET_W'(NUM_SETS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid_i) begin
            cur_q   <= req_i;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            acc_q          <= acc_n;
            hits_q         <= hits_n;
            hit_o          <= hit;
            way_used_o     <= chosen;
            set_index_o    <= cur_q.set;
            filled_empty_o <= filled;
            hit_count_o    <= hits_n;
            access_count_o <= acc_n;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[src/set_assoc_cache_lru_lookup_core.sv]
`timescale 1ns / 1ps
// Tag store of a set-associative cache (up to 8 ways, 1024 sets) with true LRU
// replacement. Each address word returns one result: hit, way used, set index,
// whether an invalid way was filled, and saturating hit and access counts.
// After reset the block clears the valid bits of every set (full is
// high meanwhile; configuration writes are taken). Then, for each word, the
// lookup engine reads the set row from the row RAM (one read and one write
// port), compares the ways in use, picks the hit way, else an invalid way,
// else the LRU victim, and writes the row back when the result register is
// free. A 2-entry input queue and 1-entry result register decouple both sides.
module set_assoc_cache_lru_lookup_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [sacl_pkg::ADDR_W-1:0]   address_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          hit_o,
  output logic [sacl_pkg::WAY_W-1:0]    way_used_o,
  output logic [sacl_pkg::SET_W-1:0]    set_index_o,
  output logic                          filled_empty_o,
  output logic [sacl_pkg::CNT_W-1:0]    hit_count_o,
  output logic [sacl_pkg::CNT_W-1:0]    access_count_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sacl_pkg::PADDR_W-1:0]  paddr,
  input  logic [sacl_pkg::PDATA_W-1:0]  pwdata,
  output logic [sacl_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import sacl_pkg::*;

  logic [WAYS_W-1:0] ways_q;
  logic [OFF_W-1:0]  off_q;
  logic [SETB_W-1:0] setb_q;
  logic              busy, req_valid, req_pop;
  req_t              req;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_comb begin
    case (reg_idx)
      REG_WAYS: prdata = PDATA_W'(ways_q);
      REG_OFF:  prdata = PDATA_W'(off_q);
      REG_SETB: prdata = PDATA_W'(setb_q);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q <= WAYS_W'(1);
      off_q  <= OFF_W'(2);
      setb_q <= SETB_W'(10);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WAYS: ways_q <= pwdata[WAYS_W-1:0];
        REG_OFF:  off_q  <= pwdata[OFF_W-1:0];
        REG_SETB: setb_q <= pwdata[SETB_W-1:0];
        default:  ;
      endcase
    end
  end

  sacl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .address_i     (address_i),
    .offset_bits_i (off_q),
    .set_bits_i    (setb_q),
    .busy_i        (busy),
    .req_pop_i     (req_pop),
    .req_valid_o   (req_valid),
    .req_o         (req)
  );

  sacl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ways_in_use_i  (ways_q),
    .req_valid_i    (req_valid),
    .req_i          (req),
    .req_pop_o      (req_pop),
    .busy_o         (busy),
    .pop            (pop),
    .empty          (empty),
    .hit_o          (hit_o),
    .way_used_o     (way_used_o),
    .set_index_o    (set_index_o),
    .filled_empty_o (filled_empty_o),
    .hit_count_o    (hit_count_o),
    .access_count_o (access_count_o)
  );

  a_clr_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> full) else $error("word accepted during clear");

  a_hit_not_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(hit_o && filled_empty_o)) else $error("hit and fill together");

  a_cnt_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (hit_count_o <= access_count_o)) else $error("hits exceed accesses");

  a_clr_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> empty) else $error("result during clear");
endmodule

[bench/tb_set_assoc_cache_lru_lookup_core.sv]
`timescale 1ns / 1ps
module tb_set_assoc_cache_lru_lookup_core;
  import sacl_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic [SET_W-1:0] set;
    logic             filled;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] accesses;
  } lookup_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    bit          known;
    lookup_t     res;
  } dir_row_t;

  typedef struct {
    int ways, off, setb, gap, stall, count;
    bit hold, drain;
  } phase_t;

  logic                clk_i, rst_ni;
  logic                push, full, empty, pop;
  logic [ADDR_W-1:0]   address_i;
  logic                hit_o, filled_empty_o;
  logic [WAY_W-1:0]    way_used_o;
  logic [SET_W-1:0]    set_index_o;
  logic [CNT_W-1:0]    hit_count_o, access_count_o;
  logic                psel, penable, pwrite, pready;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata, prdata;

  set_assoc_cache_lru_lookup_core dut (.*);

  // predictor state
  bit                 line_vld [NUM_WAYS*NUM_SETS];
  logic [TAG_W-1:0]   line_tag [NUM_WAYS*NUM_SETS];
  logic [CNT_W-1:0]   line_stamp [NUM_WAYS*NUM_SETS];
  logic [CNT_W-1:0]   acc_cnt, hit_cnt;
  logic [WAYS_W-1:0]  cfg_ways;
  logic [OFF_W-1:0]   cfg_off;
  logic [SETB_W-1:0]  cfg_setb;

  lookup_t     lookup_q[$];
  int          errors, words_sent, words_seen, hits_seen, cfg_writes;
  int          gap_pct, stall_pct, idle_cycles;
  bit          hold_req;
  logic [31:0] addr_pool[16];

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic lookup_t cache_lookup(input logic [31:0] a);
    int unsigned ways, off, sb, set, base, w, chosen;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] oldest;
    bit found, hit, filled;
    lookup_t r;
    ways = (cfg_ways == 0) ? 1 : (cfg_ways > NUM_WAYS ? NUM_WAYS : cfg_ways);
    off = (cfg_off > MAX_OFF) ? MAX_OFF : cfg_off;
    sb = (cfg_setb > MAX_SETB) ? MAX_SETB : cfg_setb;
    set = (a >> off) & ((32'd1 << sb) - 1);
    tag = a >> (off + sb);
    base = set * NUM_WAYS;
    found = 0; hit = 0; filled = 0; chosen = 0;
    for (w = 0; w < ways && !found; w++)
      if (line_vld[base+w] && line_tag[base+w] == tag) begin
        chosen = w; found = 1; hit = 1;
      end
    for (w = 0; w < ways && !found; w++)
      if (!line_vld[base+w]) begin
        chosen = w; found = 1; filled = 1;
      end
    if (!found) begin
      oldest = line_stamp[base];
      for (w = 1; w < ways; w++)
        if (line_stamp[base+w] < oldest) begin
          oldest = line_stamp[base+w];
          chosen = w;
        end
    end
    line_vld[base+chosen] = 1;
    line_tag[base+chosen] = tag;
    line_stamp[base+chosen] = acc_cnt;
    if (acc_cnt != '1) acc_cnt++;
    if (hit && hit_cnt != '1) hit_cnt++;
    r.hit = hit;
    r.way = chosen[WAY_W-1:0];
    r.set = set[SET_W-1:0];
    r.filled = filled;
    r.hits = hit_cnt;
    r.accesses = acc_cnt;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    $display("mismatch on word %0d: %s got %0h expected %0h", words_seen, field, got, exp_v);
    errors++;
  endtask

  task automatic push_word(input logic [31:0] a, input bit known, input lookup_t typed);
    lookup_t p;
    while ($urandom_range(0, 99) < gap_pct) begin
      push <= 0;
      @(posedge clk_i);
    end
    push <= 1;
    address_i <= a;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    p = cache_lookup(a);
    lookup_q.push_back(known ? typed : p);
    words_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    push <= 0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_WAYS: cfg_ways = val[WAYS_W-1:0];
      REG_OFF:  cfg_off = val[OFF_W-1:0];
      REG_SETB: cfg_setb = val[SETB_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // result side
  initial begin
    pop = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    lookup_t e;
    if (rst_ni && pop && !empty) begin
      words_seen++;
      if (hit_o) hits_seen++;
      if (lookup_q.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        errors++;
      end else begin
        e = lookup_q.pop_front();
        if (hit_o !== e.hit) report_mismatch("hit", hit_o, e.hit);
        if (way_used_o !== e.way) report_mismatch("way_used", way_used_o, e.way);
        if (set_index_o !== e.set) report_mismatch("set_index", set_index_o, e.set);
        if (filled_empty_o !== e.filled)
          report_mismatch("filled_empty", filled_empty_o, e.filled);
        if (hit_count_o !== e.hits) report_mismatch("hit_count", hit_count_o, e.hits);
        if (access_count_o !== e.accesses)
          report_mismatch("access_count", access_count_o, e.accesses);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  dir_row_t dir_tab[$];
  phase_t   phases[$];

  initial begin
    logic [31:0] a;
    int r, k;
    push = 0; address_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    rst_ni = 0; hold_req = 0; idle_cycles = 0;
    errors = 0; words_sent = 0; words_seen = 0; hits_seen = 0; cfg_writes = 0;
    gap_pct = 0; stall_pct = 0;
    cfg_ways = 1; cfg_off = 2; cfg_setb = 10;
    acc_cnt = 0; hit_cnt = 0;
    foreach (line_vld[i]) line_vld[i] = 0;
    foreach (addr_pool[i]) addr_pool[i] = $urandom & 32'h0000_3fff;

    // reset config: one way, 4-byte blocks, 1024 sets
    dir_tab = '{
      '{0, REG_WAYS, 32'h0000_0000, 1, '{0, 0, 0, 1, 0, 1}},
      '{0, REG_WAYS, 32'h0000_0000, 1, '{1, 0, 0, 0, 1, 2}},
      '{0, REG_WAYS, 32'hffff_ffff, 1, '{0, 0, 1023, 1, 1, 3}},
      '{0, REG_WAYS, 32'h0000_1000, 1, '{0, 0, 0, 0, 1, 4}},
      // out-of-range settings clamp
      '{1, REG_WAYS, 15, 0, '0}, '{1, REG_OFF, 31, 0, '0}, '{1, REG_SETB, 15, 0, '0},
      '{0, REG_WAYS, 32'h8000_0000, 0, '0},
      '{0, REG_WAYS, 32'h7fff_ffff, 0, '0},
      '{0, REG_WAYS, 32'h8000_0000, 0, '0},
      '{1, REG_WAYS, 0, 0, '0},
      '{0, REG_WAYS, 32'h5555_aaaa, 0, '0},
      // fully associative, one set, byte blocks
      '{1, REG_WAYS, 8, 0, '0}, '{1, REG_OFF, 0, 0, '0}, '{1, REG_SETB, 0, 0, '0},
      '{0, REG_WAYS, 1, 0, '0}, '{0, REG_WAYS, 2, 0, '0}, '{0, REG_WAYS, 3, 0, '0},
      '{0, REG_WAYS, 4, 0, '0}, '{0, REG_WAYS, 5, 0, '0}, '{0, REG_WAYS, 6, 0, '0},
      '{0, REG_WAYS, 7, 0, '0}, '{0, REG_WAYS, 8, 0, '0}, '{0, REG_WAYS, 2, 0, '0},
      '{0, REG_WAYS, 9, 0, '0}, '{0, REG_WAYS, 1, 0, '0}, '{0, REG_WAYS, 3, 0, '0}
    };

    phases = '{
      '{8, 2, 3, 0, 0, 250, 0, 0},
      '{4, 4, 6, 88, 0, 200, 0, 0},
      '{8, 0, 0, 0, 88, 200, 0, 0},
      '{1, 16, 10, 20, 20, 200, 0, 0},
      '{15, 31, 15, 20, 20, 150, 0, 0},
      '{0, 5, 2, 0, 0, 220, 1, 0},
      '{3, 6, 4, 20, 20, 200, 0, 0},
      '{8, 3, 2, 0, 0, 250, 0, 1},
      '{2, 1, 1, 88, 88, 150, 0, 0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
      else push_word(dir_tab[i].value, dir_tab[i].known, dir_tab[i].res);
    end

    foreach (phases[p]) begin
      write_reg(REG_WAYS, phases[p].ways);
      write_reg(REG_OFF, phases[p].off);
      write_reg(REG_SETB, phases[p].setb);
      gap_pct = phases[p].gap;
      stall_pct = phases[p].stall;
      if (phases[p].hold) hold_req = 1;
      for (k = 0; k < phases[p].count; k++) begin
        if (phases[p].drain && k == phases[p].count / 2) begin
          push <= 0;
          while (lookup_q.size() != 0) @(posedge clk_i);
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
          a = addr_pool[$urandom_range(0, 15)];
          a[1:0] = $urandom_range(0, 3);
        end else if (r < 85) begin
          a = $urandom & 32'h0000_3fff;
          addr_pool[$urandom_range(0, 15)] = a;
        end else begin
          a = $urandom;
        end
        push_word(a, 0, '0);
      end
    end

    push <= 0;
    gap_pct = 0;
    stall_pct = 0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d address words checked, %0d hits, %0d register writes", words_seen,
             hits_seen, cfg_writes);
    $display("covered clamped and extreme geometries, fills, LRU evictions and backpressure");
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
